// ===== sv/rtfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtfd_pkg: shared types and constants of the RFID tag frame dedup block
// Holds the frame constants, the event codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rtfd_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W    = 8;
    localparam int EV_W      = 3;
    localparam int CFG_W     = 9;
    localparam int ID_HIGH_W = 32;
    localparam int ID_LOW_W  = 64;
    localparam int ID_HIGH_BYTES = 4;
    localparam int ID_LOW_BYTES  = 8;

    // Frame layout.
    localparam int HEAD_BYTES = 3;
    localparam int STATUS_POS = 5;
    localparam int ID_START   = 8;
    localparam int NOTICE_LEN = 24;

    // Byte values.
    localparam logic [BYTE_W-1:0] END_BYTE       = 8'h7e;
    localparam logic [BYTE_W-1:0] HEAD_SYNC      = 8'hbb;
    localparam logic [BYTE_W-1:0] NOTICE_TYPE    = 8'h02;
    localparam logic [BYTE_W-1:0] NOTICE_CMD     = 8'h22;
    localparam logic [BYTE_W-1:0] RESP_TYPE      = 8'h01;
    localparam logic [BYTE_W-1:0] RESP_CMD       = 8'hff;
    localparam logic [BYTE_W-1:0] NOT_FOUND_CODE = 8'h15;

    // Default tag limit after reset.
    localparam logic [CFG_W-1:0] TAG_LIMIT_RESET = 9'd200;

    // Event codes reported with each result.
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_NEW_TAG   = 3'd1;
    localparam logic [EV_W-1:0] EV_DUPLICATE = 3'd2;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd3;
    localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd4;
    localparam logic [EV_W-1:0] EV_OVERFLOW  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // take the input byte and update the frame state
        logic search_start;  // clear the search index
        logic rd_issue;      // read the table entry at the search index
        logic set_full;      // report a full table
        logic set_dup;       // report a duplicate ID
        logic store;         // append the captured ID to the table
        logic load_out;      // load the result into the output register
    } rtfd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_notice;     // the accepted byte completed a notice frame
        logic full;          // stored count has reached the limit
        logic count_zero;    // table holds no entries
        logic issue_done;    // every stored entry has been read
        logic hit;           // the entry just read equals the captured ID
        logic miss_end;      // the last entry was read and did not match
        logic out_free;      // output register can take a result
    } rtfd_sts_t;

endpackage

`default_nettype wire

// ===== sv/rtfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtfd_ctrl: sequencing controller of the RFID tag frame dedup block
// Steps one received byte through capture, the table search, the store and
// the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtfd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rtfd_pkg::rtfd_sts_t sts,
    output rtfd_pkg::rtfd_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_STORE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands. The notice check is known in the accept
    // cycle, so that cycle picks between the table path and a direct result.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = sts.is_notice ? ST_CHECK : ST_RESULT;
                end
            end
            ST_CHECK: begin
                if (sts.full) begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_RESULT;
                end else if (sts.count_zero) begin
                    state_next = ST_STORE;
                end else begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.rd_issue = !sts.issue_done;
                if (sts.hit) begin
                    cmd.set_dup = 1'b1;
                    state_next  = ST_RESULT;
                end else if (sts.miss_end) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Assertions.
    a_store_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> $past(state_reg == ST_SEARCH || state_reg == ST_CHECK))
        else $error("table store not preceded by a check or a search");

    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_CHECK || state_reg == ST_RESULT))
        else $error("accepted byte did not move to its check or result");

    a_single_report: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.set_full, cmd.set_dup, cmd.store}) <= 1)
        else $error("more than one table outcome in one cycle");

endmodule

`default_nettype wire

// ===== sv/rtfd_datapath.sv =====
// ----------------------------------------------------------------------------
// rtfd_datapath: frame capture, tag table and result register
// Captures header, status and ID bytes by frame position, checks the frame
// on an end byte, searches the tag table one entry per cycle and holds the
// result for the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module rtfd_datapath #(
    parameter int MAX_TAGS  = 256,
    parameter int BUF_DEPTH = 256,
    parameter int CNT_W     = 9,
    parameter int DATA_W    = 112
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rtfd_pkg::rtfd_cmd_t            cmd,
    output rtfd_pkg::rtfd_sts_t                 sts,
    input  wire logic [rtfd_pkg::BYTE_W-1:0]    s_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [rtfd_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [DATA_W-1:0]                   m_tdata
);

    localparam int POS_W = $clog2(BUF_DEPTH);
    localparam int LEN_W = POS_W + 1;
    localparam int AW    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CMP_W = (CNT_W > rtfd_pkg::CFG_W) ? CNT_W : rtfd_pkg::CFG_W;
    localparam int ID_W  = rtfd_pkg::ID_HIGH_W + rtfd_pkg::ID_LOW_W;

    // Frame state.
    logic [POS_W-1:0]                 frame_pos_reg;
    logic [rtfd_pkg::BYTE_W-1:0]      head_reg [rtfd_pkg::HEAD_BYTES];
    logic [rtfd_pkg::BYTE_W-1:0]      status_reg;
    logic [rtfd_pkg::ID_HIGH_W-1:0]   cap_high_reg;
    logic [rtfd_pkg::ID_LOW_W-1:0]    cap_low_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [rtfd_pkg::CFG_W-1:0]       tag_limit_reg;
    logic [rtfd_pkg::EV_W-1:0]        ev_reg;

    logic [rtfd_pkg::BYTE_W-1:0]      head_next [rtfd_pkg::HEAD_BYTES];
    logic [rtfd_pkg::BYTE_W-1:0]      status_next;
    logic [rtfd_pkg::ID_HIGH_W-1:0]   cap_high_next;
    logic [rtfd_pkg::ID_LOW_W-1:0]    cap_low_next;
    logic [LEN_W-1:0]                 len;
    logic                             is_notice;
    logic                             is_not_found;
    logic                             wrap;

    // Capture the byte at its frame position.
    always_comb begin
        for (int k = 0; k < rtfd_pkg::HEAD_BYTES; k++) begin
            head_next[k] = head_reg[k];
            if (frame_pos_reg == POS_W'(k)) begin
                head_next[k] = s_tdata;
            end
        end
        status_next = status_reg;
        if (frame_pos_reg == POS_W'(rtfd_pkg::STATUS_POS)) begin
            status_next = s_tdata;
        end
        cap_high_next = cap_high_reg;
        for (int k = 0; k < rtfd_pkg::ID_HIGH_BYTES; k++) begin
            if (frame_pos_reg == POS_W'(rtfd_pkg::ID_START + k)) begin
                cap_high_next[(rtfd_pkg::ID_HIGH_BYTES-1-k)*rtfd_pkg::BYTE_W +:
                              rtfd_pkg::BYTE_W] = s_tdata;
            end
        end
        cap_low_next = cap_low_reg;
        for (int k = 0; k < rtfd_pkg::ID_LOW_BYTES; k++) begin
            if (frame_pos_reg ==
                POS_W'(rtfd_pkg::ID_START + rtfd_pkg::ID_HIGH_BYTES + k)) begin
                cap_low_next[(rtfd_pkg::ID_LOW_BYTES-1-k)*rtfd_pkg::BYTE_W +:
                             rtfd_pkg::BYTE_W] = s_tdata;
            end
        end
    end

    // Frame checks on the updated header and status bytes.
    assign len = {1'b0, frame_pos_reg} + LEN_W'(1);

    assign is_notice = (s_tdata == rtfd_pkg::END_BYTE) &&
                       (head_next[0] == rtfd_pkg::HEAD_SYNC) &&
                       (head_next[1] == rtfd_pkg::NOTICE_TYPE) &&
                       (head_next[2] == rtfd_pkg::NOTICE_CMD) &&
                       (len == LEN_W'(rtfd_pkg::NOTICE_LEN));

    assign is_not_found = (s_tdata == rtfd_pkg::END_BYTE) &&
                          (head_next[0] == rtfd_pkg::HEAD_SYNC) &&
                          !is_notice &&
                          (head_next[1] == rtfd_pkg::RESP_TYPE) &&
                          (head_next[2] == rtfd_pkg::RESP_CMD) &&
                          (len >= LEN_W'(rtfd_pkg::STATUS_POS + 1)) &&
                          (status_next == rtfd_pkg::NOT_FOUND_CODE);

    assign wrap = (len == LEN_W'(BUF_DEPTH));

    // Frame registers and event code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= '0;
            status_reg    <= '0;
            cap_high_reg  <= '0;
            cap_low_reg   <= '0;
            for (int k = 0; k < rtfd_pkg::HEAD_BYTES; k++) begin
                head_reg[k] <= '0;
            end
            ev_reg <= rtfd_pkg::EV_NONE;
        end else if (cmd.accept) begin
            head_reg     <= head_next;
            status_reg   <= status_next;
            cap_high_reg <= cap_high_next;
            cap_low_reg  <= cap_low_next;
            if (is_notice || is_not_found || wrap) begin
                frame_pos_reg <= '0;
            end else begin
                frame_pos_reg <= len[POS_W-1:0];
            end
            if (is_not_found) begin
                ev_reg <= rtfd_pkg::EV_NOT_FOUND;
            end else if (wrap && !is_notice) begin
                ev_reg <= rtfd_pkg::EV_OVERFLOW;
            end else begin
                ev_reg <= rtfd_pkg::EV_NONE;
            end
        end else if (cmd.set_full) begin
            ev_reg <= rtfd_pkg::EV_FULL;
        end else if (cmd.set_dup) begin
            ev_reg <= rtfd_pkg::EV_DUPLICATE;
        end else if (cmd.store) begin
            ev_reg <= rtfd_pkg::EV_NEW_TAG;
        end
    end

    // Tag limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_limit_reg <= rtfd_pkg::TAG_LIMIT_RESET;
        end else if (cfg_we) begin
            tag_limit_reg <= cfg_wdata;
        end
    end

    // Tag table: one write port for the append, one registered read port
    // for the search.
    logic [ID_W-1:0]  table_mem [MAX_TAGS];
    logic [ID_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;
    logic             id_equal;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            table_mem[count_reg[AW-1:0]] <= {cap_high_reg, cap_low_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= table_mem[idx_reg[AW-1:0]];
        end
    end

    // Search index and read tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_issue;
            rd_last_reg  <= cmd.rd_issue && (idx_reg + CNT_W'(1) == count_reg);
            if (cmd.search_start) begin
                idx_reg <= '0;
            end else if (cmd.rd_issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // Stored count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.store) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    logic [CMP_W-1:0] limit_eff;

    assign limit_eff = (CMP_W'(tag_limit_reg) < CMP_W'(MAX_TAGS)) ?
                       CMP_W'(tag_limit_reg) : CMP_W'(MAX_TAGS);

    assign id_equal = (rd_data_reg == {cap_high_reg, cap_low_reg});

    // Status to the controller.
    always_comb begin
        sts            = '0;
        sts.is_notice  = is_notice;
        sts.full       = (CMP_W'(count_reg) >= limit_eff);
        sts.count_zero = (count_reg == '0);
        sts.issue_done = (idx_reg == count_reg);
        sts.hit        = rd_valid_reg && id_equal;
        sts.miss_end   = rd_valid_reg && rd_last_reg && !id_equal;
        sts.out_free   = !m_tvalid || m_tready;
    end

    // Result word: event, count, ID high, ID low from the lowest bit up.
    logic [DATA_W-1:0] out_word;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;

    always_comb begin
        out_word = '0;
        out_word[rtfd_pkg::EV_W-1:0] = ev_reg;
        out_word[rtfd_pkg::EV_W +: CNT_W] = count_reg;
        out_word[rtfd_pkg::EV_W + CNT_W +: rtfd_pkg::ID_HIGH_W] = cap_high_reg;
        out_word[rtfd_pkg::EV_W + CNT_W + rtfd_pkg::ID_HIGH_W +: rtfd_pkg::ID_LOW_W] =
            cap_low_reg;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Assertions.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(MAX_TAGS))
        else $error("stored tag count beyond the table depth");

    a_store_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("store did not advance the count by one");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[rtfd_pkg::EV_W-1:0] <= rtfd_pkg::EV_OVERFLOW)
        else $error("result carries an undefined event code");

endmodule

`default_nettype wire

// ===== sv/rfid_tag_frame_dedup.sv =====
// ----------------------------------------------------------------------------
// rfid_tag_frame_dedup: reader frame parser with tag ID duplicate filter
// Top level joining the sequencing controller and the capture, table and
// result datapath.
// ----------------------------------------------------------------------------
// Each received byte on the slave stream gives exactly one result transfer on
// the master stream, with the event code, the stored tag count and the last
// captured 96-bit ID. A byte that does not complete a notice frame goes from
// the idle state to the result state and is loaded into the output register
// once that register is free; a new byte is taken only after that load. A
// notice frame's end byte goes through the check state, the table search,
// which reads one entry per cycle through the single registered read port of
// its memory, and the store of a new ID; a full table skips both, an empty
// one the search. The output register lets the next byte be taken while a
// result still waits on the master side. The table needs no clearing pass:
// only entries below the stored count are ever read.
`default_nettype none

module rfid_tag_frame_dedup #(
    parameter int MAX_TAGS  = 256,
    parameter int BUF_DEPTH = 256,
    localparam int CNT_W    = $clog2(MAX_TAGS + 1),
    localparam int DATA_W   = ((rtfd_pkg::EV_W + CNT_W + rtfd_pkg::ID_HIGH_W +
                                rtfd_pkg::ID_LOW_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Fields from bit 0: rx_byte[7:0].
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rtfd_pkg::BYTE_W-1:0]    s_tdata,
    // Fields from bit 0: event_res[3], tag_count[CNT_W], id_high[32],
    // id_low[64], zero padding.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [DATA_W-1:0]                   m_tdata,
    // Tag limit register write.
    input  wire logic                           cfg_we,
    input  wire logic [rtfd_pkg::CFG_W-1:0]     cfg_wdata
);

    rtfd_pkg::rtfd_cmd_t cmd;
    rtfd_pkg::rtfd_sts_t sts;

    // Sequencing controller.
    rtfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Capture, table and result datapath.
    rtfd_datapath #(
        .MAX_TAGS  (MAX_TAGS),
        .BUF_DEPTH (BUF_DEPTH),
        .CNT_W     (CNT_W),
        .DATA_W    (DATA_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/rfid_tag_frame_dedup_tb.sv =====
// ----------------------------------------------------------------------------
// rfid_tag_frame_dedup_tb: self-checking bench for the reader frame dedup block
// Streams reader bytes through the slave port and checks every result
// transfer against a byte-level tracker of frames and the tag table.
// Directed frames come first, then random phases of notice and response
// frames with repeated IDs, broken frames and noise, under several tag limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rfid_tag_frame_dedup_tb;

    localparam int MAX_TAGS  = 256;
    localparam int BUF_DEPTH = 256;
    localparam int CNT_W     = $clog2(MAX_TAGS + 1);
    localparam int DATA_W    = ((rtfd_pkg::EV_W + CNT_W + rtfd_pkg::ID_HIGH_W +
                                 rtfd_pkg::ID_LOW_W + 7) / 8) * 8;
    localparam int ID_BYTES  = rtfd_pkg::ID_HIGH_BYTES + rtfd_pkg::ID_LOW_BYTES;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = MAX_TAGS + 40;
    localparam int POOL_SIZE   = 16;

    typedef struct {
        logic [rtfd_pkg::EV_W-1:0]      ev;
        logic [CNT_W-1:0]               count;
        logic [rtfd_pkg::ID_HIGH_W-1:0] id_hi;
        logic [rtfd_pkg::ID_LOW_W-1:0]  id_lo;
    } tag_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rtfd_pkg::BYTE_W-1:0]     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [DATA_W-1:0]               m_tdata;
    logic                            cfg_we = 1'b0;
    logic [rtfd_pkg::CFG_W-1:0]      cfg_wdata = '0;

    // Bench state shared by the stimulus, driver and monitor.
    logic [rtfd_pkg::BYTE_W-1:0]     rx_bytes_q[$];
    tag_result_t                     expected_q[$];
    int                              error_count = 0;
    int                              bytes_queued = 0;
    bit                              idle_on = 1'b0;
    logic                            hold_req = 1'b0;
    logic                            hold_ack = 1'b0;
    int                              hold_left = 0;

    // Tracker copy of the block state.
    int                              trk_pos = 0;
    logic [rtfd_pkg::BYTE_W-1:0]     trk_head[rtfd_pkg::HEAD_BYTES];
    logic [rtfd_pkg::BYTE_W-1:0]     trk_status = '0;
    logic [rtfd_pkg::ID_HIGH_W-1:0]  trk_cap_hi = '0;
    logic [rtfd_pkg::ID_LOW_W-1:0]   trk_cap_lo = '0;
    int                              trk_count = 0;
    logic [rtfd_pkg::CFG_W-1:0]      trk_limit = rtfd_pkg::TAG_LIMIT_RESET;
    logic [rtfd_pkg::ID_HIGH_W-1:0]  tag_tab_hi[MAX_TAGS];
    logic [rtfd_pkg::ID_LOW_W-1:0]   tag_tab_lo[MAX_TAGS];

    // IDs reused across frames so that duplicates occur often.
    logic [rtfd_pkg::ID_HIGH_W-1:0]  pool_hi[POOL_SIZE];
    logic [rtfd_pkg::ID_LOW_W-1:0]   pool_lo[POOL_SIZE];

    rfid_tag_frame_dedup #(
        .MAX_TAGS  (MAX_TAGS),
        .BUF_DEPTH (BUF_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic flag_error(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Tag table lookup and append for a complete notice frame.
    function automatic logic [rtfd_pkg::EV_W-1:0] store_tag_id();
        int lim;
        lim = (int'(trk_limit) < MAX_TAGS) ? int'(trk_limit) : MAX_TAGS;
        if (trk_count >= lim)
            return rtfd_pkg::EV_FULL;
        for (int i = 0; i < trk_count; i++) begin
            if (tag_tab_hi[i] == trk_cap_hi && tag_tab_lo[i] == trk_cap_lo)
                return rtfd_pkg::EV_DUPLICATE;
        end
        tag_tab_hi[trk_count] = trk_cap_hi;
        tag_tab_lo[trk_count] = trk_cap_lo;
        trk_count++;
        return rtfd_pkg::EV_NEW_TAG;
    endfunction

    // Advance the frame tracker by one received byte and queue its result.
    function automatic void track_rx_byte(input logic [rtfd_pkg::BYTE_W-1:0] b);
        tag_result_t r;
        logic [rtfd_pkg::EV_W-1:0] ev;
        bit done;
        int k;
        ev = rtfd_pkg::EV_NONE;
        done = 1'b0;
        if (trk_pos < rtfd_pkg::HEAD_BYTES) begin
            trk_head[trk_pos] = b;
        end else if (trk_pos == rtfd_pkg::STATUS_POS) begin
            trk_status = b;
        end else if (trk_pos >= rtfd_pkg::ID_START &&
                     trk_pos < rtfd_pkg::ID_START + ID_BYTES) begin
            k = trk_pos - rtfd_pkg::ID_START;
            if (k < rtfd_pkg::ID_HIGH_BYTES)
                trk_cap_hi[(rtfd_pkg::ID_HIGH_BYTES - 1 - k) * 8 +: 8] = b;
            else
                trk_cap_lo[(ID_BYTES - 1 - k) * 8 +: 8] = b;
        end
        trk_pos++;

        // Frame check on an end byte.
        if (b == rtfd_pkg::END_BYTE && trk_head[0] == rtfd_pkg::HEAD_SYNC) begin
            if (trk_head[1] == rtfd_pkg::NOTICE_TYPE && trk_head[2] == rtfd_pkg::NOTICE_CMD &&
                trk_pos == rtfd_pkg::NOTICE_LEN) begin
                ev = store_tag_id();
                trk_pos = 0;
                done = 1'b1;
            end else if (trk_head[1] == rtfd_pkg::RESP_TYPE &&
                         trk_head[2] == rtfd_pkg::RESP_CMD &&
                         trk_pos >= rtfd_pkg::STATUS_POS + 1 &&
                         trk_status == rtfd_pkg::NOT_FOUND_CODE) begin
                ev = rtfd_pkg::EV_NOT_FOUND;
                trk_pos = 0;
                done = 1'b1;
            end
        end

        // Buffer wrap, reported only when no frame ended here.
        if (trk_pos >= BUF_DEPTH) begin
            trk_pos = 0;
            if (!done)
                ev = rtfd_pkg::EV_OVERFLOW;
        end

        r.ev    = ev;
        r.count = trk_count[CNT_W-1:0];
        r.id_hi = trk_cap_hi;
        r.id_lo = trk_cap_lo;
        expected_q.push_back(r);
    endfunction

    // Driver: offers queued bytes, idling at random when enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_rx_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (rx_bytes_q.size() != 0 && !(idle_on && $urandom_range(99, 0) < 30)) begin
                    s_tdata  <= rx_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and requested by a toggle.
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        tag_result_t want;
        logic [rtfd_pkg::EV_W-1:0]      got_ev;
        logic [CNT_W-1:0]               got_count;
        logic [rtfd_pkg::ID_HIGH_W-1:0] got_hi;
        logic [rtfd_pkg::ID_LOW_W-1:0]  got_lo;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_ev    = m_tdata[0 +: rtfd_pkg::EV_W];
                got_count = m_tdata[rtfd_pkg::EV_W +: CNT_W];
                got_hi    = m_tdata[rtfd_pkg::EV_W + CNT_W +: rtfd_pkg::ID_HIGH_W];
                got_lo    = m_tdata[rtfd_pkg::EV_W + CNT_W + rtfd_pkg::ID_HIGH_W +:
                                    rtfd_pkg::ID_LOW_W];
                if (expected_q.size() == 0) begin
                    flag_error("result transfer with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (got_ev !== want.ev)
                        flag_error($sformatf("event_res got %0d want %0d", got_ev, want.ev));
                    if (got_count !== want.count)
                        flag_error($sformatf("tag_count got %0d want %0d",
                                             got_count, want.count));
                    if (got_hi !== want.id_hi)
                        flag_error($sformatf("id_high got %h want %h", got_hi, want.id_hi));
                    if (got_lo !== want.id_lo)
                        flag_error($sformatf("id_low got %h want %h", got_lo, want.id_lo));
                end
            end
            m_tready <= (hold_left == 0) && !(idle_on && $urandom_range(99, 0) < 30);
        end
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("[rfid_tag_frame_dedup] ERROR");
        $finish;
    end

    task automatic push_rx(input logic [rtfd_pkg::BYTE_W-1:0] b);
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    // A random byte that can never end a frame.
    function automatic logic [rtfd_pkg::BYTE_W-1:0] plain_byte();
        logic [rtfd_pkg::BYTE_W-1:0] b;
        b = rtfd_pkg::BYTE_W'($urandom_range(255, 0));
        if (b == rtfd_pkg::END_BYTE)
            b = ~rtfd_pkg::END_BYTE;
        return b;
    endfunction

    // Notice frame of a given length; the end byte is the last one.
    task automatic push_notice(input logic [rtfd_pkg::ID_HIGH_W-1:0] hi,
                               input logic [rtfd_pkg::ID_LOW_W-1:0] lo,
                               input int len);
        int k;
        for (int p = 0; p < len - 1; p++) begin
            k = p - rtfd_pkg::ID_START;
            if (p == 0)
                push_rx(rtfd_pkg::HEAD_SYNC);
            else if (p == 1)
                push_rx(rtfd_pkg::NOTICE_TYPE);
            else if (p == 2)
                push_rx(rtfd_pkg::NOTICE_CMD);
            else if (k >= 0 && k < rtfd_pkg::ID_HIGH_BYTES)
                push_rx(hi[(rtfd_pkg::ID_HIGH_BYTES - 1 - k) * 8 +: 8]);
            else if (k >= rtfd_pkg::ID_HIGH_BYTES && k < ID_BYTES)
                push_rx(lo[(ID_BYTES - 1 - k) * 8 +: 8]);
            else
                push_rx(rtfd_pkg::BYTE_W'($urandom_range(255, 0)));
        end
        push_rx(rtfd_pkg::END_BYTE);
    endtask

    // Response frame with a given status and some padding before the end byte.
    task automatic push_response(input logic [rtfd_pkg::BYTE_W-1:0] status, input int pad);
        push_rx(rtfd_pkg::HEAD_SYNC);
        push_rx(rtfd_pkg::RESP_TYPE);
        push_rx(rtfd_pkg::RESP_CMD);
        push_rx(rtfd_pkg::BYTE_W'($urandom_range(255, 0)));
        push_rx(rtfd_pkg::BYTE_W'($urandom_range(255, 0)));
        push_rx(status);
        repeat (pad) push_rx(plain_byte());
        push_rx(rtfd_pkg::END_BYTE);
    endtask

    // Wait until all bytes are taken and every result has arrived.
    task automatic wait_drained();
        do @(negedge aclk);
        while (rx_bytes_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    endtask

    task automatic write_tag_limit(input logic [rtfd_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        trk_limit = value;
        @(negedge aclk);
    endtask

    // Stimulus phases.
    initial begin
        int phase;
        int idx;
        logic [rtfd_pkg::BYTE_W-1:0] st;
        for (int i = 0; i < rtfd_pkg::HEAD_BYTES; i++)
            trk_head[i] = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = $urandom;
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: an all-ones ID with an end byte inside its low half, then
        // a no-tag-found response of the shortest valid length.
        push_notice('1, {8'hff, rtfd_pkg::END_BYTE, 48'hffff_ffff_ffff},
                    rtfd_pkg::NOTICE_LEN);
        push_response(rtfd_pkg::NOT_FOUND_CODE, 0);
        wait_drained();

        phase = 0;
        while (bytes_queued < 540) begin
            repeat (4) @(posedge aclk);
            case (phase)
                0: write_tag_limit(9'd511);
                1: write_tag_limit(9'd0);
                2: write_tag_limit(9'd256);
                default: begin
                    case ($urandom_range(4, 0))
                        0: write_tag_limit(rtfd_pkg::CFG_W'(trk_count));
                        1: write_tag_limit(rtfd_pkg::CFG_W'(trk_count + $urandom_range(3, 1)));
                        2: write_tag_limit(9'd511);
                        3: write_tag_limit(9'd0);
                        default: write_tag_limit(rtfd_pkg::CFG_W'($urandom_range(255, 1)));
                    endcase
                end
            endcase

            // The first phase runs without any idling on either side.
            idle_on = (phase != 0);
            if (phase == 1)
                hold_req <= ~hold_req;

            // Well-formed frames with random content.
            repeat ($urandom_range(5, 2)) begin
                if ($urandom_range(3, 0) != 0) begin
                    if ($urandom_range(9, 0) < 7) begin
                        idx = $urandom_range(POOL_SIZE - 1, 0);
                        push_notice(pool_hi[idx], pool_lo[idx], rtfd_pkg::NOTICE_LEN);
                    end else begin
                        push_notice($urandom, {$urandom, $urandom}, rtfd_pkg::NOTICE_LEN);
                    end
                end else begin
                    push_response(rtfd_pkg::NOT_FOUND_CODE, $urandom_range(5, 0));
                end
            end

            // Now and then broken frames and noise, which leave the
            // position off the frame start and stale header bytes behind.
            if (phase % 3 == 2) begin
                repeat ($urandom_range(4, 2)) begin
                    case ($urandom_range(3, 0))
                        0: push_notice($urandom, {$urandom, $urandom},
                                       $urandom_range(1, 0) ? 20 : 26);
                        1: begin
                            st = rtfd_pkg::BYTE_W'($urandom_range(255, 0));
                            if (st == rtfd_pkg::NOT_FOUND_CODE)
                                st = ~rtfd_pkg::NOT_FOUND_CODE;
                            push_response(st, $urandom_range(3, 0));
                        end
                        default: begin
                            repeat ($urandom_range(30, 3)) begin
                                if ($urandom_range(3, 0) == 0)
                                    push_rx(rtfd_pkg::END_BYTE);
                                else
                                    push_rx(rtfd_pkg::BYTE_W'($urandom_range(255, 0)));
                            end
                        end
                    endcase
                end
            end
            wait_drained();

            // Realign to a frame start by running the buffer to its wrap.
            if (trk_pos != 0) begin
                repeat (BUF_DEPTH - trk_pos) push_rx(plain_byte());
                wait_drained();
            end
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_q.size()));
        if (error_count == 0)
            $display("[rfid_tag_frame_dedup] OK");
        else
            $display("[rfid_tag_frame_dedup] ERROR");
        $finish;
    end

endmodule

// ===== rfid_tag_frame_dedup.f =====
sv/rtfd_pkg.sv
sv/rtfd_ctrl.sv
sv/rtfd_datapath.sv
sv/rfid_tag_frame_dedup.sv
test/rfid_tag_frame_dedup_tb.sv
